/* rtl/core/cts_pkg.sv */
`timescale 1ns / 1ps

package cts_pkg;

   localparam int WORD_BITS     = 48;
   localparam int FRACTION_BITS = 24;
   localparam int OUT_BITS      = 48;
   localparam int COUNT_BITS    = 32;
   localparam int GAIN_BITS     = 47;
   localparam int CSR_IDX_BITS  = 3;

   localparam int DIGIT_BITS = 4;
   localparam int DIGITS     = WORD_BITS / DIGIT_BITS;
   localparam int DCNT_BITS  = $clog2(DIGITS);
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int QUOT_BITS  = PROD_BITS - FRACTION_BITS;
   localparam int ACC_BITS   = WORD_BITS + DIGIT_BITS;

   localparam int ADDR_BITS = 6;
   localparam int MEM_AW    = 5;
   localparam int MEM_DEPTH = 22;
   localparam int NUM_STATE = 16;
   localparam int PC_BITS   = 7;
   localparam int PROG_LEN  = 83;
   localparam logic [PC_BITS-1:0] PC_LAST = PC_BITS'(PROG_LEN - 1);

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [ADDR_BITS-1:0] addr_type;

   localparam word_type WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // fixed-point constants
   localparam word_type C_ST     = WORD_BITS'(64'd1678);
   localparam word_type C_KO     = WORD_BITS'(64'd16777216000);
   localparam word_type C_DO     = WORD_BITS'(64'd16777216);
   localparam word_type C_INVMO  = WORD_BITS'(64'd33554432);
   localparam word_type C_L      = WORD_BITS'(64'd1677722);
   localparam word_type C_RW     = WORD_BITS'(64'd503316);
   localparam word_type C_INVRW  = WORD_BITS'(64'd559240533);
   localparam word_type C_HALFRW = WORD_BITS'(64'd251658);
   localparam word_type C_TWORW  = WORD_BITS'(64'd1118481067);
   localparam word_type C_JN     = WORD_BITS'(64'd1677722);
   localparam word_type C_INVJN  = WORD_BITS'(64'd167772160);
   localparam word_type C_POS0   = WORD_BITS'(64'd2516582);

   localparam word_type RST_TPOS = WORD_BITS'(64'd33554432);
   localparam word_type RST_FCMD = WORD_BITS'(64'd83886080);
   localparam word_type RST_GAIN = WORD_BITS'(64'd167772160);
   localparam word_type RST_WC   = WORD_BITS'(64'd8388608000);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_TPOS = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_TVEL = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_FCMD = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_KP   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_KV   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_KF   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_WC   = 3'd6;

   // register file entries
   localparam addr_type A_PPOS   = 6'd0;
   localparam addr_type A_PVEL   = 6'd1;
   localparam addr_type A_PRATE  = 6'd2;
   localparam addr_type A_PINTEG = 6'd3;
   localparam addr_type A_PTORQ  = 6'd4;
   localparam addr_type A_QPOS   = 6'd5;
   localparam addr_type A_QVEL   = 6'd6;
   localparam addr_type A_QRATE  = 6'd7;
   localparam addr_type A_QINTEG = 6'd8;
   localparam addr_type A_QTORQ  = 6'd9;
   localparam addr_type A_LPOS   = 6'd10;
   localparam addr_type A_LVEL   = 6'd11;
   localparam addr_type A_FPUSH  = 6'd12;
   localparam addr_type A_FPULL  = 6'd13;
   localparam addr_type A_EPUSH  = 6'd14;
   localparam addr_type A_EPULL  = 6'd15;
   localparam addr_type A_T0     = 6'd16;
   localparam addr_type A_T1     = 6'd17;
   localparam addr_type A_T2     = 6'd18;
   localparam addr_type A_T3     = 6'd19;
   localparam addr_type A_T4     = 6'd20;
   localparam addr_type A_T5     = 6'd21;

   // constant and config operands
   localparam addr_type A_ZERO   = 6'd32;
   localparam addr_type A_ST     = 6'd33;
   localparam addr_type A_KO     = 6'd34;
   localparam addr_type A_DO     = 6'd35;
   localparam addr_type A_INVMO  = 6'd36;
   localparam addr_type A_L      = 6'd37;
   localparam addr_type A_RW     = 6'd38;
   localparam addr_type A_INVRW  = 6'd39;
   localparam addr_type A_HALFRW = 6'd40;
   localparam addr_type A_TWORW  = 6'd41;
   localparam addr_type A_JN     = 6'd42;
   localparam addr_type A_INVJN  = 6'd43;
   localparam addr_type A_TPOS   = 6'd48;
   localparam addr_type A_TVEL   = 6'd49;
   localparam addr_type A_FCMD   = 6'd50;
   localparam addr_type A_KP     = 6'd51;
   localparam addr_type A_KV     = 6'd52;
   localparam addr_type A_KF     = 6'd53;
   localparam addr_type A_WC     = 6'd54;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_GE,
      OP_SELZ
   } op_type;

   typedef struct packed {
      op_type   op;
      addr_type dst;
      addr_type a;
      addr_type b;
   } uop_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_FETCH,
      S_EXEC,
      S_MWAIT,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      M_IDLE,
      M_STEP,
      M_ROUND,
      M_SAT
   } mul_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   function automatic uop_type mk(op_type op, addr_type d, addr_type a, addr_type b);
      uop_type u;
      u.op  = op;
      u.dst = d;
      u.a   = a;
      u.b   = b;
      return u;
   endfunction

   function automatic word_type init_value(logic [MEM_AW-1:0] idx);
      word_type v;
      v = '0;
      if (ADDR_BITS'(idx) == A_PPOS) v = -C_POS0;
      if (ADDR_BITS'(idx) == A_QPOS) v = C_POS0;
      return v;
   endfunction

   function automatic uop_type uop_at(logic [PC_BITS-1:0] pc);
      uop_type u;
      case (pc)
         // contact forces
         7'd0:  u = mk(OP_SUB,  A_T0,    A_LPOS,   A_L);
         7'd1:  u = mk(OP_ADD,  A_T1,    A_LPOS,   A_L);
         7'd2:  u = mk(OP_SUB,  A_T2,    A_PPOS,   A_T0);
         7'd3:  u = mk(OP_MUL,  A_T2,    A_KO,     A_T2);
         7'd4:  u = mk(OP_SUB,  A_T3,    A_PVEL,   A_LVEL);
         7'd5:  u = mk(OP_MUL,  A_T3,    A_DO,     A_T3);
         7'd6:  u = mk(OP_ADD,  A_T2,    A_T2,     A_T3);
         7'd7:  u = mk(OP_GE,   A_ZERO,  A_PPOS,   A_T0);
         7'd8:  u = mk(OP_SELZ, A_FPUSH, A_T2,     A_ZERO);
         7'd9:  u = mk(OP_SUB,  A_T2,    A_QPOS,   A_T1);
         7'd10: u = mk(OP_MUL,  A_T2,    A_KO,     A_T2);
         7'd11: u = mk(OP_SUB,  A_T3,    A_QVEL,   A_LVEL);
         7'd12: u = mk(OP_MUL,  A_T3,    A_DO,     A_T3);
         7'd13: u = mk(OP_ADD,  A_T2,    A_T2,     A_T3);
         7'd14: u = mk(OP_GE,   A_ZERO,  A_T1,     A_QPOS);
         7'd15: u = mk(OP_SELZ, A_FPULL, A_T2,     A_ZERO);
         // pd terms
         7'd16: u = mk(OP_SUB,  A_T0,    A_TPOS,   A_L);
         7'd17: u = mk(OP_SUB,  A_T0,    A_T0,     A_PPOS);
         7'd18: u = mk(OP_MUL,  A_T0,    A_KP,     A_T0);
         7'd19: u = mk(OP_SUB,  A_T1,    A_TVEL,   A_PVEL);
         7'd20: u = mk(OP_MUL,  A_T1,    A_KV,     A_T1);
         7'd21: u = mk(OP_ADD,  A_T0,    A_T0,     A_T1);
         7'd22: u = mk(OP_ADD,  A_T1,    A_TPOS,   A_L);
         7'd23: u = mk(OP_SUB,  A_T1,    A_T1,     A_QPOS);
         7'd24: u = mk(OP_MUL,  A_T1,    A_KP,     A_T1);
         7'd25: u = mk(OP_SUB,  A_T2,    A_TVEL,   A_QVEL);
         7'd26: u = mk(OP_MUL,  A_T2,    A_KV,     A_T2);
         7'd27: u = mk(OP_ADD,  A_T1,    A_T1,     A_T2);
         7'd28: u = mk(OP_SUB,  A_T2,    A_FCMD,   A_FPUSH);
         7'd29: u = mk(OP_MUL,  A_T2,    A_KF,     A_T2);
         7'd30: u = mk(OP_MUL,  A_T2,    A_T2,     A_INVMO);
         7'd31: u = mk(OP_ADD,  A_T0,    A_T2,     A_T0);
         // pusher drive
         7'd32: u = mk(OP_MUL,  A_T2,    A_T0,     A_INVRW);
         7'd33: u = mk(OP_MUL,  A_T2,    A_JN,     A_T2);
         7'd34: u = mk(OP_ADD,  A_T2,    A_T2,     A_PTORQ);
         7'd35: u = mk(OP_MUL,  A_T3,    A_FPUSH,  A_HALFRW);
         7'd36: u = mk(OP_SUB,  A_T3,    A_T2,     A_T3);
         7'd37: u = mk(OP_MUL,  A_T3,    A_T3,     A_INVJN);
         7'd38: u = mk(OP_MUL,  A_T4,    A_T3,     A_ST);
         7'd39: u = mk(OP_ADD,  A_PRATE, A_PRATE,  A_T4);
         7'd40: u = mk(OP_MUL,  A_T4,    A_RW,     A_T3);
         7'd41: u = mk(OP_MUL,  A_T4,    A_T4,     A_ST);
         7'd42: u = mk(OP_ADD,  A_PVEL,  A_PVEL,   A_T4);
         7'd43: u = mk(OP_MUL,  A_T4,    A_PVEL,   A_ST);
         7'd44: u = mk(OP_ADD,  A_PPOS,  A_PPOS,   A_T4);
         7'd45: u = mk(OP_MUL,  A_T4,    A_PRATE,  A_JN);
         7'd46: u = mk(OP_MUL,  A_T4,    A_T4,     A_WC);
         7'd47: u = mk(OP_SUB,  A_PTORQ, A_PINTEG, A_T4);
         7'd48: u = mk(OP_ADD,  A_T5,    A_T2,     A_T4);
         7'd49: u = mk(OP_SUB,  A_T5,    A_T5,     A_PINTEG);
         7'd50: u = mk(OP_MUL,  A_T5,    A_T5,     A_WC);
         7'd51: u = mk(OP_MUL,  A_T5,    A_T5,     A_ST);
         7'd52: u = mk(OP_ADD,  A_PINTEG, A_PINTEG, A_T5);
         // puller drive
         7'd53: u = mk(OP_MUL,  A_T2,    A_T1,     A_INVRW);
         7'd54: u = mk(OP_MUL,  A_T2,    A_JN,     A_T2);
         7'd55: u = mk(OP_ADD,  A_T2,    A_T2,     A_QTORQ);
         7'd56: u = mk(OP_MUL,  A_T3,    A_FPULL,  A_HALFRW);
         7'd57: u = mk(OP_SUB,  A_T3,    A_T2,     A_T3);
         7'd58: u = mk(OP_MUL,  A_T3,    A_T3,     A_INVJN);
         7'd59: u = mk(OP_MUL,  A_T4,    A_T3,     A_ST);
         7'd60: u = mk(OP_ADD,  A_QRATE, A_QRATE,  A_T4);
         7'd61: u = mk(OP_MUL,  A_T4,    A_RW,     A_T3);
         7'd62: u = mk(OP_MUL,  A_T4,    A_T4,     A_ST);
         7'd63: u = mk(OP_ADD,  A_QVEL,  A_QVEL,   A_T4);
         7'd64: u = mk(OP_MUL,  A_T4,    A_QVEL,   A_ST);
         7'd65: u = mk(OP_ADD,  A_QPOS,  A_QPOS,   A_T4);
         7'd66: u = mk(OP_MUL,  A_T4,    A_QRATE,  A_JN);
         7'd67: u = mk(OP_MUL,  A_T4,    A_T4,     A_WC);
         7'd68: u = mk(OP_SUB,  A_QTORQ, A_QINTEG, A_T4);
         7'd69: u = mk(OP_ADD,  A_T5,    A_T2,     A_T4);
         7'd70: u = mk(OP_SUB,  A_T5,    A_T5,     A_QINTEG);
         7'd71: u = mk(OP_MUL,  A_T5,    A_T5,     A_WC);
         7'd72: u = mk(OP_MUL,  A_T5,    A_T5,     A_ST);
         7'd73: u = mk(OP_ADD,  A_QINTEG, A_QINTEG, A_T5);
         // object and estimates
         7'd74: u = mk(OP_ADD,  A_T0,    A_FPUSH,  A_FPULL);
         7'd75: u = mk(OP_MUL,  A_T0,    A_T0,     A_INVMO);
         7'd76: u = mk(OP_MUL,  A_T0,    A_T0,     A_ST);
         7'd77: u = mk(OP_ADD,  A_LVEL,  A_LVEL,   A_T0);
         7'd78: u = mk(OP_MUL,  A_T0,    A_LVEL,   A_ST);
         7'd79: u = mk(OP_ADD,  A_LPOS,  A_LPOS,   A_T0);
         7'd80: u = mk(OP_MUL,  A_EPUSH, A_PTORQ,  A_TWORW);
         7'd81: u = mk(OP_MUL,  A_EPULL, A_QTORQ,  A_TWORW);
         7'd82: u = mk(OP_ADD,  A_T0,    A_ZERO,   A_ZERO);
         default: u = mk(OP_ADD, A_T0, A_ZERO, A_ZERO);
      endcase
      return u;
   endfunction

endpackage

/* rtl/core/cooperative_transport_sim_step.sv */
`timescale 1ns / 1ps
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_advance
// rsp      out        rsp_valid/rsp_stall  positions, forces, estimates, elapsed_steps
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// an advancing item runs an 83-op microprogram on one shared 4-bit-digit multiplier;
// each multiply fetches, executes and waits while the multiplier steps, rounds and saturates
// an item with advance low goes from idle straight to done and runs no microprogram
// after reset an init pass loads the first 16 state-file entries; req_stall is high meanwhile
// a result waits in the output register under rsp_stall while the next item is taken

module cooperative_transport_sim_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_advance,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cts_pkg::OUT_BITS-1:0] rsp_push_position,
   output logic signed [cts_pkg::OUT_BITS-1:0] rsp_pull_position,
   output logic signed [cts_pkg::OUT_BITS-1:0] rsp_object_position,
   output logic signed [cts_pkg::OUT_BITS-1:0] rsp_push_contact_force,
   output logic signed [cts_pkg::OUT_BITS-1:0] rsp_pull_contact_force,
   output logic signed [cts_pkg::OUT_BITS-1:0] rsp_push_reaction_estimate,
   output logic signed [cts_pkg::OUT_BITS-1:0] rsp_pull_reaction_estimate,
   output logic        [cts_pkg::COUNT_BITS-1:0] rsp_elapsed_steps,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cts_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [cts_pkg::OUT_BITS-1:0]        csr_data
);

   cts_pkg::state_type state_ff, state_in;

   logic [cts_pkg::PC_BITS-1:0]    pc_ff, pc_in;
   logic [cts_pkg::MEM_AW-1:0]     init_ff, init_in;
   logic                           flag_ff, flag_in;
   logic [cts_pkg::COUNT_BITS-1:0] step_ff, step_in;
   cts_pkg::word_type              a_ff, b_ff;

   cts_pkg::word_type tpos_ff, tvel_ff, fcmd_ff, kp_ff, kv_ff, kf_ff, wc_ff;

   cts_pkg::word_type sh_ppos_ff, sh_qpos_ff, sh_lpos_ff;
   cts_pkg::word_type sh_fpush_ff, sh_fpull_ff, sh_epush_ff, sh_epull_ff;

   logic                           rsp_valid_ff;
   cts_pkg::word_type              rsp_ppos_ff, rsp_qpos_ff, rsp_lpos_ff;
   cts_pkg::word_type              rsp_fpush_ff, rsp_fpull_ff, rsp_epush_ff, rsp_epull_ff;
   logic [cts_pkg::COUNT_BITS-1:0] rsp_step_ff;

   cts_pkg::word_type mem [cts_pkg::MEM_DEPTH];

   cts_pkg::uop_type      uop;
   logic                  wr_en;
   cts_pkg::addr_type     wr_addr;
   cts_pkg::word_type     wr_data;
   cts_pkg::word_type     alu_res;
   cts_pkg::word_type     src_a, src_b;
   logic                  mul_start;
   logic                  load_rsp;
   logic                  req_take;
   cts_pkg::mul_stat_type mul_stat;
   cts_pkg::word_type     mul_res;
   logic signed [cts_pkg::WORD_BITS:0] sum_w, dif_w;

   function automatic cts_pkg::word_type sat_w(logic signed [cts_pkg::WORD_BITS:0] v);
      cts_pkg::word_type r;
      if (v[cts_pkg::WORD_BITS] != v[cts_pkg::WORD_BITS-1]) begin
         r = v[cts_pkg::WORD_BITS] ? cts_pkg::WMIN : cts_pkg::WMAX;
      end else begin
         r = v[cts_pkg::WORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic cts_pkg::word_type operand(
      cts_pkg::addr_type ad,
      cts_pkg::word_type tp, cts_pkg::word_type tv, cts_pkg::word_type fc,
      cts_pkg::word_type gp, cts_pkg::word_type gv, cts_pkg::word_type gf,
      cts_pkg::word_type wc);
      cts_pkg::word_type r;
      case (ad)
         cts_pkg::A_ST:     r = cts_pkg::C_ST;
         cts_pkg::A_KO:     r = cts_pkg::C_KO;
         cts_pkg::A_DO:     r = cts_pkg::C_DO;
         cts_pkg::A_INVMO:  r = cts_pkg::C_INVMO;
         cts_pkg::A_L:      r = cts_pkg::C_L;
         cts_pkg::A_RW:     r = cts_pkg::C_RW;
         cts_pkg::A_INVRW:  r = cts_pkg::C_INVRW;
         cts_pkg::A_HALFRW: r = cts_pkg::C_HALFRW;
         cts_pkg::A_TWORW:  r = cts_pkg::C_TWORW;
         cts_pkg::A_JN:     r = cts_pkg::C_JN;
         cts_pkg::A_INVJN:  r = cts_pkg::C_INVJN;
         cts_pkg::A_TPOS:   r = tp;
         cts_pkg::A_TVEL:   r = tv;
         cts_pkg::A_FCMD:   r = fc;
         cts_pkg::A_KP:     r = gp;
         cts_pkg::A_KV:     r = gv;
         cts_pkg::A_KF:     r = gf;
         cts_pkg::A_WC:     r = wc;
         default:           r = '0;
      endcase
      return r;
   endfunction

   cts_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (a_ff),
      .b      (b_ff),
      .stat   (mul_stat),
      .result (mul_res)
   );

   assign uop       = cts_pkg::uop_at(pc_ff);
   assign req_stall = (state_ff != cts_pkg::S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      src_a = operand(uop.a, tpos_ff, tvel_ff, fcmd_ff, kp_ff, kv_ff, kf_ff, wc_ff);
      src_b = operand(uop.b, tpos_ff, tvel_ff, fcmd_ff, kp_ff, kv_ff, kf_ff, wc_ff);
      sum_w = {a_ff[cts_pkg::WORD_BITS-1], a_ff} + {b_ff[cts_pkg::WORD_BITS-1], b_ff};
      dif_w = {a_ff[cts_pkg::WORD_BITS-1], a_ff} - {b_ff[cts_pkg::WORD_BITS-1], b_ff};
      case (uop.op)
         cts_pkg::OP_ADD:  alu_res = sat_w(sum_w);
         cts_pkg::OP_SUB:  alu_res = sat_w(dif_w);
         cts_pkg::OP_SELZ: alu_res = flag_ff ? a_ff : '0;
         default:          alu_res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cts_pkg::S_INIT;
         pc_ff        <= '0;
         init_ff      <= '0;
         flag_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         init_ff  <= init_in;
         flag_ff  <= flag_in;
         step_ff  <= step_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpos_ff <= cts_pkg::RST_TPOS;
         tvel_ff <= '0;
         fcmd_ff <= cts_pkg::RST_FCMD;
         kp_ff   <= cts_pkg::RST_GAIN;
         kv_ff   <= cts_pkg::RST_GAIN;
         kf_ff   <= cts_pkg::RST_GAIN;
         wc_ff   <= cts_pkg::RST_WC;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cts_pkg::REG_TPOS: tpos_ff <= csr_data;
            cts_pkg::REG_TVEL: tvel_ff <= csr_data;
            cts_pkg::REG_FCMD: fcmd_ff <= csr_data;
            cts_pkg::REG_KP:   kp_ff   <= {1'b0, csr_data[cts_pkg::GAIN_BITS-1:0]};
            cts_pkg::REG_KV:   kv_ff   <= {1'b0, csr_data[cts_pkg::GAIN_BITS-1:0]};
            cts_pkg::REG_KF:   kf_ff   <= {1'b0, csr_data[cts_pkg::GAIN_BITS-1:0]};
            cts_pkg::REG_WC:   wc_ff   <= {1'b0, csr_data[cts_pkg::GAIN_BITS-1:0]};
            default: ;
         endcase
      end
   end

   // state file and operand fetch
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[cts_pkg::MEM_AW-1:0]] <= wr_data;
      end
      if (state_ff == cts_pkg::S_FETCH) begin
         a_ff <= uop.a[cts_pkg::ADDR_BITS-1] ? src_a : mem[uop.a[cts_pkg::MEM_AW-1:0]];
         b_ff <= uop.b[cts_pkg::ADDR_BITS-1] ? src_b : mem[uop.b[cts_pkg::MEM_AW-1:0]];
      end
   end

   // copies of the reported entries
   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (wr_addr)
            cts_pkg::A_PPOS:  sh_ppos_ff  <= wr_data;
            cts_pkg::A_QPOS:  sh_qpos_ff  <= wr_data;
            cts_pkg::A_LPOS:  sh_lpos_ff  <= wr_data;
            cts_pkg::A_FPUSH: sh_fpush_ff <= wr_data;
            cts_pkg::A_FPULL: sh_fpull_ff <= wr_data;
            cts_pkg::A_EPUSH: sh_epush_ff <= wr_data;
            cts_pkg::A_EPULL: sh_epull_ff <= wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ppos_ff  <= sh_ppos_ff;
         rsp_qpos_ff  <= sh_qpos_ff;
         rsp_lpos_ff  <= sh_lpos_ff;
         rsp_fpush_ff <= sh_fpush_ff;
         rsp_fpull_ff <= sh_fpull_ff;
         rsp_epush_ff <= sh_epush_ff;
         rsp_epull_ff <= sh_epull_ff;
         rsp_step_ff  <= step_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      init_in   = init_ff;
      flag_in   = flag_ff;
      step_in   = step_ff;
      wr_en     = 1'b0;
      wr_addr   = uop.dst;
      wr_data   = alu_res;
      mul_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         cts_pkg::S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = cts_pkg::ADDR_BITS'(init_ff);
            wr_data = cts_pkg::init_value(init_ff);
            init_in = init_ff + 1'b1;
            if (init_ff == cts_pkg::MEM_AW'(cts_pkg::NUM_STATE - 1)) begin
               state_in = cts_pkg::S_IDLE;
            end
         end
         cts_pkg::S_IDLE: begin
            if (req_take) begin
               if (req_advance) begin
                  step_in  = step_ff + 1'b1;
                  pc_in    = '0;
                  state_in = cts_pkg::S_FETCH;
               end else begin
                  state_in = cts_pkg::S_DONE;
               end
            end
         end
         cts_pkg::S_FETCH: begin
            state_in = cts_pkg::S_EXEC;
         end
         cts_pkg::S_EXEC: begin
            if (uop.op == cts_pkg::OP_MUL) begin
               mul_start = 1'b1;
               state_in  = cts_pkg::S_MWAIT;
            end else begin
               if (uop.op == cts_pkg::OP_GE) begin
                  flag_in = ($signed(a_ff) >= $signed(b_ff));
               end else begin
                  wr_en = 1'b1;
               end
               if (pc_ff == cts_pkg::PC_LAST) begin
                  state_in = cts_pkg::S_DONE;
               end else begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = cts_pkg::S_FETCH;
               end
            end
         end
         cts_pkg::S_MWAIT: begin
            if (mul_stat.done) begin
               wr_en   = 1'b1;
               wr_data = mul_res;
               if (pc_ff == cts_pkg::PC_LAST) begin
                  state_in = cts_pkg::S_DONE;
               end else begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = cts_pkg::S_FETCH;
               end
            end
         end
         cts_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = cts_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cts_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_push_position          = rsp_ppos_ff;
   assign rsp_pull_position          = rsp_qpos_ff;
   assign rsp_object_position        = rsp_lpos_ff;
   assign rsp_push_contact_force     = rsp_fpush_ff;
   assign rsp_pull_contact_force     = rsp_fpull_ff;
   assign rsp_push_reaction_estimate = rsp_epush_ff;
   assign rsp_pull_reaction_estimate = rsp_epull_ff;
   assign rsp_elapsed_steps          = rsp_step_ff;

   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> state_ff == cts_pkg::S_MWAIT)
      else $error("multiplier finished outside wait state");

   a_mul_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy && !mul_stat.done)
      else $error("multiplier started while busy");

   a_step_only_on_item: assert property (@(posedge clock) disable iff (reset)
      !req_take |=> $stable(step_ff))
      else $error("step count changed without an item");

endmodule

/* rtl/core/cts_mul.sv */
`timescale 1ns / 1ps

module cts_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cts_pkg::word_type    a,
   input  cts_pkg::word_type    b,
   output cts_pkg::mul_stat_type stat,
   output cts_pkg::word_type    result
);

   cts_pkg::mul_state_type state_ff, state_in;

   logic [cts_pkg::PROD_BITS-1:0]  p_ff, p_in;
   logic [cts_pkg::WORD_BITS-1:0]  ua_ff, ua_in;
   logic                           neg_ff, neg_in;
   logic [cts_pkg::DCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [cts_pkg::QUOT_BITS-1:0]  q_ff, q_in;

   logic [cts_pkg::WORD_BITS-1:0]  mag_a, mag_b;
   logic [cts_pkg::DIGIT_BITS-1:0] dig;
   logic [cts_pkg::ACC_BITS-1:0]   acc;
   logic [cts_pkg::PROD_BITS-1:0]  rnd;
   logic [cts_pkg::QUOT_BITS-1:0]  lim;
   logic [cts_pkg::WORD_BITS-1:0]  qlo;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cts_pkg::M_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      ua_ff  <= ua_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
   end

   always_comb begin
      mag_a = a[cts_pkg::WORD_BITS-1] ? cts_pkg::WORD_BITS'(-a) : a;
      mag_b = b[cts_pkg::WORD_BITS-1] ? cts_pkg::WORD_BITS'(-b) : b;
      dig   = p_ff[cts_pkg::DIGIT_BITS-1:0];
      acc   = cts_pkg::ACC_BITS'(p_ff[cts_pkg::PROD_BITS-1:cts_pkg::WORD_BITS]);
      for (int i = 0; i < cts_pkg::DIGIT_BITS; i++) begin
         if (dig[i]) begin
            acc = acc + (cts_pkg::ACC_BITS'(ua_ff) << i);
         end
      end
      rnd = p_ff + (cts_pkg::PROD_BITS'(1) << (cts_pkg::FRACTION_BITS - 1));
      lim = cts_pkg::QUOT_BITS'(cts_pkg::WMAX) + cts_pkg::QUOT_BITS'(neg_ff);
      qlo = q_ff[cts_pkg::WORD_BITS-1:0];
      if (q_ff > lim) begin
         result = neg_ff ? cts_pkg::WMIN : cts_pkg::WMAX;
      end else begin
         result = neg_ff ? -qlo : qlo;
      end
   end

   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      ua_in    = ua_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      q_in     = q_ff;
      stat     = '0;
      case (state_ff)
         cts_pkg::M_IDLE: begin
            if (start) begin
               p_in     = {{cts_pkg::WORD_BITS{1'b0}}, mag_b};
               ua_in    = mag_a;
               neg_in   = a[cts_pkg::WORD_BITS-1] ^ b[cts_pkg::WORD_BITS-1];
               cnt_in   = '0;
               state_in = cts_pkg::M_STEP;
            end
         end
         cts_pkg::M_STEP: begin
            stat.busy = 1'b1;
            p_in = {acc, p_ff[cts_pkg::WORD_BITS-1:cts_pkg::DIGIT_BITS]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == cts_pkg::DCNT_BITS'(cts_pkg::DIGITS - 1)) begin
               state_in = cts_pkg::M_ROUND;
            end
         end
         cts_pkg::M_ROUND: begin
            stat.busy = 1'b1;
            q_in = rnd[cts_pkg::PROD_BITS-1:cts_pkg::FRACTION_BITS];
            state_in = cts_pkg::M_SAT;
         end
         cts_pkg::M_SAT: begin
            stat.done = 1'b1;
            state_in  = cts_pkg::M_IDLE;
         end
         default: begin
            state_in = cts_pkg::M_IDLE;
         end
      endcase
   end

endmodule
